[design/sfr_pkg.sv]
package sfr_pkg;

    // Width of one received or emitted byte
    localparam int BYTE_W = 8;
    // Width of the payload position field (payloads of up to 64 bytes)
    localparam int IDX_W = 6;

    // Configuration register indexes
    localparam logic CFG_START_CODE = 1'b0;
    localparam logic CFG_END_CODE   = 1'b1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'h17;

    // Payload buffer write from the parser into the back end
    typedef struct packed {
        logic              we;
        logic              bank;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_wr;

    // Bank token: committed frame, queue head, or bank release
    typedef struct packed {
        logic valid;
        logic bank;
    } t_tok;

    // Back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_bk_state;

endpackage

[design/stuffed_frame_receiver.sv]
// Stuffed frame receiver.
// Input channel: one received byte per item on i_rx_byte (i_in_valid / o_in_stall).
// A frame is the start code, PAYLOAD_BYTES payload bytes, then the end code; a
// payload byte equal to the end code arrives doubled. A frame is committed by the
// byte that follows its unpaired end code, and that byte is parsed again.
// Output channel (o_out_valid / i_out_stall): one item per payload byte with its
// position and a last marker on the final byte.
// The parser takes one byte per cycle while o_in_stall is low. Committed frames
// go through a two-entry bank queue to a reader that drains the two-bank payload
// buffer at one byte per cycle unless the output stalls; each byte passes the read
// stage and the output register once the reader has popped its bank.
// o_in_stall rises only while the bank the parser would fill is still being read,
// which happens when the output is stalled long enough for two frames to pile up.
// Configuration (start code index 0, end code index 1) is written by the user only
// while idle; the block does not enforce it. Reset restores codes 2 and 23, closes
// any open frame and empties the queue and read pipeline; buffer contents are not
// cleared. A valid item stalled by i_out_stall holds; the read pipeline freezes.
module stuffed_frame_receiver #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [sfr_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [sfr_pkg::BYTE_W-1:0] o_payload_byte,
    output logic [sfr_pkg::IDX_W-1:0]  o_byte_index,
    output logic                       o_last
);

    sfr_pkg::t_wr  wr;
    sfr_pkg::t_tok tok;
    sfr_pkg::t_tok head;
    sfr_pkg::t_tok rel;
    logic          pop;

    sfr_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_wr        (wr),
        .o_tok       (tok),
        .i_rel       (rel)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok),
        .o_head  (head),
        .i_pop   (pop)
    );

    sfr_back #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_head         (head),
        .o_pop          (pop),
        .o_rel          (rel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last         (o_last)
    );

endmodule

[design/sfr_front.sv]
module sfr_front #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [sfr_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0] i_rx_byte,
    output sfr_pkg::t_wr               o_wr,
    output sfr_pkg::t_tok              o_tok,
    input  sfr_pkg::t_tok              i_rel
);

    localparam int FW = $clog2(PAYLOAD_BYTES + 1);
    localparam int IW = sfr_pkg::IDX_W;
    localparam logic [FW-1:0] FILL_FULL = FW'(PAYLOAD_BYTES);

    logic [sfr_pkg::BYTE_W-1:0] r_start_code;
    logic [sfr_pkg::BYTE_W-1:0] r_end_code;
    logic                       r_in_frame, n_in_frame;
    logic                       r_end_pending, n_end_pending;
    logic [FW-1:0]              r_fill, n_fill;
    logic                       r_wbank, n_wbank;
    logic [1:0]                 r_busy, n_busy;

    logic accept;
    logic is_end;
    logic is_start;
    logic pend_eff;
    logic commit;
    logic close_frame;
    logic stay_open;
    logic store_byte;

    // Hold input while the bank being filled is still owned by the back end
    assign o_in_stall = r_busy[r_wbank];
    assign accept     = i_in_valid && !o_in_stall;
    assign is_end     = (i_rx_byte == r_end_code);
    assign is_start   = (i_rx_byte == r_start_code);

    // Parse one byte: end-byte pairing, commit, close, start and store
    always_comb begin
        n_in_frame    = r_in_frame;
        n_end_pending = r_end_pending;
        n_fill        = r_fill;
        n_wbank       = r_wbank;
        pend_eff      = r_end_pending && !is_end;
        commit        = 1'b0;
        close_frame   = 1'b0;
        stay_open     = 1'b0;
        store_byte    = 1'b0;
        if (accept) begin
            if (is_end && !r_end_pending) begin
                n_end_pending = 1'b1;
            end else begin
                n_end_pending = 1'b0;
                commit        = pend_eff && r_in_frame && (r_fill == FILL_FULL);
                close_frame   = pend_eff || (r_in_frame && (r_fill >= FILL_FULL));
                stay_open     = r_in_frame && !close_frame;
                if (!stay_open) begin
                    n_in_frame = is_start;
                    if (is_start) begin
                        n_fill = '0;
                    end
                end else if (r_fill < FILL_FULL) begin
                    store_byte = 1'b1;
                    n_fill     = r_fill + FW'(1);
                end
                if (commit) begin
                    n_wbank = !r_wbank;
                end
            end
        end
    end

    // Track which payload banks the back end still has to drain
    always_comb begin
        n_busy = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (commit) begin
            n_busy[r_wbank] = 1'b1;
        end
    end

    // Drive buffer write and commit token
    always_comb begin
        o_wr.we    = store_byte;
        o_wr.bank  = r_wbank;
        o_wr.idx   = IW'(r_fill);
        o_wr.data  = i_rx_byte;
        o_tok.valid = commit;
        o_tok.bank  = r_wbank;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= sfr_pkg::START_CODE_RST;
            r_end_code   <= sfr_pkg::END_CODE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sfr_pkg::CFG_START_CODE) begin
                r_start_code <= i_cfg_data;
            end
            if (i_cfg_index == sfr_pkg::CFG_END_CODE) begin
                r_end_code <= i_cfg_data;
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_end_pending <= 1'b0;
            r_fill        <= '0;
            r_wbank       <= 1'b0;
            r_busy        <= '0;
        end else begin
            r_in_frame    <= n_in_frame;
            r_end_pending <= n_end_pending;
            r_fill        <= n_fill;
            r_wbank       <= n_wbank;
            r_busy        <= n_busy;
        end
    end

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond payload size");

    a_commit_flips_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_wbank != $past(r_wbank)) && r_busy[$past(r_wbank)])
        else $error("commit did not hand over the bank");

endmodule

[design/sfr_queue.sv]
module sfr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfr_pkg::t_tok i_push,
    output sfr_pkg::t_tok o_head,
    input  logic          i_pop
);

    logic [1:0] r_data;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // Expose oldest committed bank
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.bank  = r_data[r_rd_ptr];

    // Store token payload
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_data[r_wr_ptr] <= i_push.bank;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_count != 2'd2) || i_pop)
        else $error("push into full token queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("pop from empty token queue");

endmodule

[design/sfr_back.sv]
module sfr_back #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sfr_pkg::t_wr               i_wr,
    input  sfr_pkg::t_tok              i_head,
    output logic                       o_pop,
    output sfr_pkg::t_tok              o_rel,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [sfr_pkg::BYTE_W-1:0] o_payload_byte,
    output logic [sfr_pkg::IDX_W-1:0]  o_byte_index,
    output logic                       o_last
);

    localparam int IW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam logic [IW-1:0] IDX_LAST = IW'(PAYLOAD_BYTES - 1);

    logic [sfr_pkg::BYTE_W-1:0] r_mem [DEPTH];

    sfr_pkg::t_bk_state r_state, n_state;
    logic               r_bank, n_bank;
    logic [IW-1:0]      r_idx, n_idx;

    logic                       r_s1_valid;
    logic [IW-1:0]              r_s1_idx;
    logic                       r_s1_last;
    logic [sfr_pkg::BYTE_W-1:0] r_s1_data;

    logic                       r_out_valid;
    logic [IW-1:0]              r_out_idx;
    logic                       r_out_last;
    logic [sfr_pkg::BYTE_W-1:0] r_out_data;

    logic advance;
    logic issue;
    logic idx_last;

    assign advance  = !r_out_valid || !i_out_stall;
    assign idx_last = (r_idx == IDX_LAST);

    // Sequence reads of one committed bank, one byte per cycle unless the output stalls
    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        issue       = 1'b0;
        o_rel.valid = 1'b0;
        o_rel.bank  = r_bank;
        unique case (r_state)
            sfr_pkg::BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_bank  = i_head.bank;
                    n_idx   = '0;
                    n_state = sfr_pkg::BK_READ;
                end
            end
            sfr_pkg::BK_READ: begin
                if (advance) begin
                    issue = 1'b1;
                    if (idx_last) begin
                        o_rel.valid = 1'b1;
                        n_state     = sfr_pkg::BK_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: n_state = sfr_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfr_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bank <= n_bank;
        r_idx  <= n_idx;
    end

    // Payload buffer: two banks, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[{i_wr.bank, i_wr.idx[IW-1:0]}] <= i_wr.data;
        end
    end

    // Read stage and output register advance together; hold when stalled
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_data  <= r_mem[{r_bank, r_idx}];
            r_s1_idx   <= r_idx;
            r_s1_last  <= idx_last;
            r_out_data <= r_s1_data;
            r_out_idx  <= r_s1_idx;
            r_out_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= issue;
            r_out_valid <= r_s1_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_data;
    assign o_byte_index   = sfr_pkg::IDX_W'(r_out_idx);
    assign o_last         = r_out_last;

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_idx == IDX_LAST))
        else $error("last marker off the final payload position");

    a_release_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rel.valid |-> (r_state == sfr_pkg::BK_READ) && issue)
        else $error("bank released outside a read");

endmodule

[tb/sv/stuffed_frame_receiver_tb.sv]
`timescale 1ns / 1ps

module stuffed_frame_receiver_tb;

    localparam int PAYLOAD_BYTES = 8;
    localparam int DRAIN_CYCLES  = PAYLOAD_BYTES + 8;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 200;

    typedef struct {
        logic [sfr_pkg::BYTE_W-1:0] payload_byte;
        logic [sfr_pkg::IDX_W-1:0]  byte_index;
        logic                       last;
    } t_payload_item;

    // DUT ports
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic                       i_cfg_index = sfr_pkg::CFG_START_CODE;
    logic [sfr_pkg::BYTE_W-1:0] i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic [sfr_pkg::BYTE_W-1:0] i_rx_byte   = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [sfr_pkg::BYTE_W-1:0] o_payload_byte;
    logic [sfr_pkg::IDX_W-1:0]  o_byte_index;
    logic                       o_last;

    // Frame parser tracking state
    logic [sfr_pkg::BYTE_W-1:0] cur_start = sfr_pkg::START_CODE_RST;
    logic [sfr_pkg::BYTE_W-1:0] cur_end   = sfr_pkg::END_CODE_RST;
    logic [sfr_pkg::BYTE_W-1:0] buf_bytes [PAYLOAD_BYTES];
    int                         buf_fill   = 0;
    bit                         frame_open = 1'b0;
    bit                         end_seen   = 1'b0;

    t_payload_item              exp_payload_q[$];
    logic [sfr_pkg::BYTE_W-1:0] pl_bytes[$];

    // Traffic shaping and bookkeeping
    bit  src_gaps   = 1'b0;
    bit  sink_gaps  = 1'b0;
    int  hold_req   = 0;
    int  hold_done  = 0;
    int  stall_left = 0;
    int  bytes_sent = 0;
    int  frames_out = 0;
    int  items_seen = 0;
    int  in_stalls  = 0;
    int  fail_count = 0;
    int  cycles     = 0;

    stuffed_frame_receiver #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_payload_byte(o_payload_byte),
        .o_byte_index  (o_byte_index),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    // Advance the parser by one received byte and queue any committed payload
    function automatic void parse_rx_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
        t_payload_item r;
        if (b == cur_end && !end_seen) begin
            end_seen = 1'b1;
            return;
        end
        if (b == cur_end && end_seen) begin
            end_seen = 1'b0;
        end
        // unpaired end followed by this byte with a full buffer: commit
        if (end_seen && frame_open && buf_fill == PAYLOAD_BYTES) begin
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                r.payload_byte = buf_bytes[i];
                r.byte_index   = sfr_pkg::IDX_W'(i);
                r.last         = (i == PAYLOAD_BYTES - 1);
                exp_payload_q.push_back(r);
            end
            frames_out++;
        end
        if (end_seen || (frame_open && buf_fill >= PAYLOAD_BYTES)) begin
            end_seen   = 1'b0;
            frame_open = 1'b0;
        end
        if (!frame_open) begin
            if (b == cur_start) begin
                frame_open = 1'b1;
                buf_fill   = 0;
            end
            return;
        end
        if (buf_fill < PAYLOAD_BYTES) begin
            buf_bytes[buf_fill] = b;
            buf_fill++;
        end
    endfunction

    // Byte biased toward the codes and the extremes
    function automatic logic [sfr_pkg::BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return cur_end;
        if (r < 20) return cur_start;
        if (r < 28) return 8'h00;
        if (r < 36) return 8'hFF;
        return sfr_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    // Offer one byte, hold it until accepted, then update the prediction
    task automatic send_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
        int gap;
        if (src_gaps && $urandom_range(0, 99) < 20) begin
            gap = gap_len();
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    // Send pl_bytes framed and stuffed, optionally without the closing code
    task automatic send_frame(input bit close);
        if (cur_start == cur_end) begin
            // a pending end would swallow the opening code; break it first
            if (end_seen) send_byte(cur_start ^ 8'h01);
            send_byte(cur_start);
        end
        send_byte(cur_start);
        foreach (pl_bytes[i]) begin
            send_byte(pl_bytes[i]);
            if (pl_bytes[i] == cur_end) send_byte(pl_bytes[i]);
        end
        if (close) send_byte(cur_end);
    endtask

    task automatic fill_random_payload(input int n);
        pl_bytes.delete();
        repeat (n) pl_bytes.push_back(pick_byte());
    endtask

    task automatic write_codes(input logic [sfr_pkg::BYTE_W-1:0] s,
                               input logic [sfr_pkg::BYTE_W-1:0] e);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sfr_pkg::CFG_START_CODE;
        i_cfg_data  <= s;
        @(posedge i_clk);
        cur_start = s;
        i_cfg_index <= sfr_pkg::CFG_END_CODE;
        i_cfg_data  <= e;
        @(posedge i_clk);
        cur_end = e;
        i_cfg_we <= 1'b0;
    endtask

    // Idle the input and wait for every expected item plus the pipeline tail
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (exp_payload_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_basic_frames();
        write_codes(sfr_pkg::START_CODE_RST, sfr_pkg::END_CODE_RST);
        src_gaps  <= 1'b0;
        sink_gaps <= 1'b0;
        pl_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h00};
        send_frame(1'b1);
        // literal end codes arrive doubled; start codes inside are plain payload
        pl_bytes = '{sfr_pkg::END_CODE_RST, sfr_pkg::START_CODE_RST, 8'h3C,
                     sfr_pkg::END_CODE_RST, 8'hC3, 8'hFE, sfr_pkg::START_CODE_RST,
                     8'h11};
        send_frame(1'b1);
        send_byte(8'h40);
        wait_drained();
    endtask

    task automatic test_dropped_frames();
        src_gaps  <= 1'b1;
        sink_gaps <= 1'b1;
        // early end: too few bytes before the unpaired end
        pl_bytes = '{8'h10, 8'h20, 8'h30};
        send_frame(1'b1);
        send_byte(8'h44);
        // overlong: the ninth payload byte drops the frame
        fill_random_payload(10);
        send_frame(1'b1);
        // noise outside a frame, an unpaired end and a doubled end
        send_byte(8'h99);
        send_byte(cur_end);
        send_byte(8'h33);
        send_byte(cur_end);
        send_byte(cur_end);
        // recover with a clean frame
        fill_random_payload(PAYLOAD_BYTES);
        send_frame(1'b1);
        send_byte(8'h5E);
        wait_drained();
    endtask

    task automatic test_code_extremes();
        write_codes(8'h00, 8'hFF);
        pl_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h12, 8'h00, 8'hED, 8'hFF, 8'h7E};
        send_frame(1'b1);
        send_byte(8'h81);
        wait_drained();
        write_codes(8'hFF, 8'h00);
        pl_bytes = '{8'h00, 8'hFF, 8'h00, 8'h21, 8'hFF, 8'hDE, 8'h00, 8'hE7};
        send_frame(1'b1);
        send_byte(8'h18);
        wait_drained();
        // start and end share one code
        write_codes(8'h5A, 8'h5A);
        pl_bytes = '{8'h5A, 8'h01, 8'hA5, 8'h5A, 8'h02, 8'h03, 8'h04, 8'h05};
        send_frame(1'b1);
        send_byte(8'h5B);
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_codes(sfr_pkg::START_CODE_RST, sfr_pkg::END_CODE_RST);
        src_gaps  <= 1'b0;
        sink_gaps <= 1'b0;
        hold_req  <= hold_req + 1;
        repeat (5) begin
            fill_random_payload(PAYLOAD_BYTES);
            send_frame(1'b1);
        end
        send_byte(8'h66);
        wait_drained();
    endtask

    // Mostly well-formed frames with random content, the rest broken or noise
    task automatic run_random_phase(input int n_items);
        int target;
        int r;
        target = bytes_sent + n_items;
        while (bytes_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                fill_random_payload(PAYLOAD_BYTES);
                send_frame(1'b1);
                if ($urandom_range(0, 99) < 30) send_byte(pick_byte());
            end else if (r < 78) begin
                fill_random_payload($urandom_range(1, PAYLOAD_BYTES - 1));
                send_frame(1'b1);
            end else if (r < 85) begin
                fill_random_payload($urandom_range(PAYLOAD_BYTES + 1, PAYLOAD_BYTES + 3));
                send_frame(1'($urandom_range(0, 1)));
            end else if (r < 92) begin
                fill_random_payload($urandom_range(0, PAYLOAD_BYTES));
                send_frame(1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(pick_byte());
            end
        end
        // commit anything left pending
        send_byte(cur_start ^ cur_end ^ 8'h3C);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [sfr_pkg::BYTE_W-1:0] s;
        logic [sfr_pkg::BYTE_W-1:0] e;
        s = sfr_pkg::BYTE_W'($urandom_range(0, 255));
        e = s ^ sfr_pkg::BYTE_W'($urandom_range(1, 255));
        src_gaps  <= 1'b1;
        sink_gaps <= 1'b1;
        write_codes(s, e);
        run_random_phase(RANDOM_ITEMS / 5);
        src_gaps  <= 1'b0;
        sink_gaps <= 1'b0;
        write_codes(8'h00, 8'hFF);
        run_random_phase(RANDOM_ITEMS / 5);
        src_gaps  <= 1'b1;
        sink_gaps <= 1'b0;
        write_codes(8'hFF, 8'h00);
        run_random_phase(RANDOM_ITEMS / 5);
        src_gaps  <= 1'b0;
        sink_gaps <= 1'b1;
        s = sfr_pkg::BYTE_W'($urandom_range(0, 255));
        write_codes(s, s);
        run_random_phase(RANDOM_ITEMS / 5);
        src_gaps  <= 1'b1;
        sink_gaps <= 1'b1;
        write_codes(sfr_pkg::START_CODE_RST, sfr_pkg::END_CODE_RST);
        run_random_phase(RANDOM_ITEMS / 5);
    endtask

    // Output stall: a requested long hold, random gaps, or ready
    always @(posedge i_clk) begin
        if (hold_req != hold_done) begin
            hold_done   <= hold_done + 1;
            stall_left  <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (sink_gaps && $urandom_range(0, 99) < 20) begin
            stall_left  <= gap_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted payload item with the oldest expectation
    always @(posedge i_clk) begin
        t_payload_item x;
        if (i_rst_n && i_in_valid && o_in_stall) in_stalls++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            items_seen++;
            if (exp_payload_q.size() == 0) begin
                $error("unexpected payload item: byte %0h index %0d last %0b",
                       o_payload_byte, o_byte_index, o_last);
                fail_count++;
            end else begin
                x = exp_payload_q.pop_front();
                if (o_payload_byte !== x.payload_byte) begin
                    $error("payload_byte: expected %0h, got %0h", x.payload_byte, o_payload_byte);
                    fail_count++;
                end
                if (o_byte_index !== x.byte_index) begin
                    $error("byte_index: expected %0d, got %0d", x.byte_index, o_byte_index);
                    fail_count++;
                end
                if (o_last !== x.last) begin
                    $error("last: expected %0b, got %0b", x.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycles, exp_payload_q.size());
            $display("[stuffed_frame_receiver] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_frames();
        test_dropped_frames();
        test_code_extremes();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        if (exp_payload_q.size() != 0) begin
            $error("%0d payload items never arrived", exp_payload_q.size());
            fail_count++;
        end
        $display("sent %0d bytes across six code settings, %0d frames committed",
                 bytes_sent, frames_out);
        $display("checked %0d payload items, input held off for %0d cycles",
                 items_seen, in_stalls);
        if (fail_count == 0) begin
            $display("[stuffed_frame_receiver] OK");
        end else begin
            $display("[stuffed_frame_receiver] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
design/sfr_pkg.sv
design/sfr_front.sv
design/sfr_queue.sv
design/sfr_back.sv
design/stuffed_frame_receiver.sv
tb/sv/stuffed_frame_receiver_tb.sv
